[src/ehr_pkg.sv]
// ----------------------------------------------------------------------------
// ehr_pkg
// Shared widths, register indexes, constants and types for the heart-rate
// estimator built on a threshold R-peak detector.
// ----------------------------------------------------------------------------
package ehr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int TS_W        = 32;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int BPM_W       = 9;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;
   localparam int DIV_W       = 32;
   localparam int DIV_CNT_W   = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_THR_HIGH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LIM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IVL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IVL    = 3'd4;

   localparam logic [CSR_W-1:0] THR_HIGH_RST  = 16'd2300;
   localparam logic [CSR_W-1:0] THR_LOW_RST   = 16'd2200;
   localparam logic [CSR_W-1:0] WIDTH_LIM_RST = 16'd25;
   localparam logic [CSR_W-1:0] MIN_IVL_RST   = 16'd214;
   localparam logic [CSR_W-1:0] MAX_IVL_RST   = 16'd3000;

   localparam logic [CSR_W-1:0] WIDTH_SAT     = 16'hFFFF;
   localparam logic [DIV_W-1:0] MS_PER_MIN    = 32'd60000;
   localparam logic [DIV_W-1:0] BPM_MIN       = 32'd20;
   localparam logic [DIV_W-1:0] BPM_MAX       = 32'd280;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

endpackage

[src/ehr_div.sv]
// ----------------------------------------------------------------------------
// ehr_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ehr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  ehr_pkg::div_req_type      div_req,
   output logic                      done,
   output logic [ehr_pkg::DIV_W-1:0] quotient
);
   import ehr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       rem_shift;
   logic [DIV_W:0]       diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/ehr_ring.sv]
// ----------------------------------------------------------------------------
// ehr_ring
// Peak-time window memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ehr_ring #(
   parameter int DEPTH = 12,
   parameter int AW    = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [ehr_pkg::TS_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [ehr_pkg::TS_W-1:0] rd_data
);
   import ehr_pkg::*;

   logic [TS_W-1:0] mem [DEPTH];
   logic [TS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ecg_heart_rate_from_peaks.sv]
// ----------------------------------------------------------------------------
// ecg_heart_rate_from_peaks
// Threshold R-peak detector with a ring window of peak times and a heart
// rate of 60000 over the mean peak interval.
// A request that closes an accepted peak with two or more peaks in the window
// goes through the ring read and one or two passes through the shared divider
// before S_OUT; other requests go from idle straight to S_OUT.
// Throughput: one request at a time; the next request is taken once the
// previous result is loaded into the output register.
// Reset: synchronous; CSRs return to defaults, window empty, rate invalid.
// ----------------------------------------------------------------------------
module ecg_heart_rate_from_peaks #(
   parameter int WINDOW_PEAKS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ehr_pkg::REQ_DATA_W-1:0] req_tdata,  // sample[15:0], timestamp_ms[47:16]
   input  logic                           req_tuser,  // lead_fault
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ehr_pkg::RSP_DATA_W-1:0] rsp_tdata,  // heart_rate_bpm[8:0], zero pad
   output logic                           rsp_tuser,  // rate_valid
   input  logic                           csr_we,
   input  logic [ehr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ehr_pkg::CSR_W-1:0]      csr_wdata
);
   import ehr_pkg::*;

   localparam int IDX_W = (WINDOW_PEAKS > 1) ? $clog2(WINDOW_PEAKS) : 1;
   localparam int CNT_W = $clog2(WINDOW_PEAKS + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_DIV1 = 3'd2;
   localparam logic [2:0] S_DIV2 = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CSR_W-1:0] thr_high_ff, thr_high_in;
   logic [CSR_W-1:0] thr_low_ff, thr_low_in;
   logic [CSR_W-1:0] width_lim_ff, width_lim_in;
   logic [CSR_W-1:0] min_ivl_ff, min_ivl_in;
   logic [CSR_W-1:0] max_ivl_ff, max_ivl_in;
   logic [CSR_W-1:0] width_cnt_ff, width_cnt_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [TS_W-1:0]  last_end_ff, last_end_in;
   logic [BPM_W-1:0] rate_ff, rate_in;
   logic             valid_ff, valid_in;
   logic [TS_W-1:0]  ts_ff, ts_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BPM_W-1:0] rsp_bpm_ff, rsp_bpm_in;
   logic             rsp_user_ff, rsp_user_in;

   logic signed [SAMPLE_W-1:0] sample;
   logic [TS_W-1:0]  ts;
   logic             req_fire;
   logic [CSR_W-1:0] cnt_inc;
   logic [TS_W-1:0]  interval;
   logic             peak_ok;
   logic [IDX_W-1:0] widx_nxt;
   logic [CNT_W-1:0] fill_nxt;
   logic [SUM_W-1:0] old_sum;
   logic [IDX_W-1:0] oldest_idx;

   logic             ring_wr_en;
   logic             ring_rd_en;
   logic [TS_W-1:0]  ring_rd_data;
   div_req_type      div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;

   assign sample   = $signed(req_tdata[SAMPLE_W-1:0]);
   assign ts       = req_tdata[SAMPLE_W +: TS_W];
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      cnt_inc  = (width_cnt_ff != WIDTH_SAT) ? width_cnt_ff + 16'd1 : width_cnt_ff;
      interval = ts - last_end_ff;
      peak_ok  = (cnt_inc < width_lim_ff)
              && (interval > {16'd0, min_ivl_ff})
              && (interval <= {16'd0, max_ivl_ff});
      widx_nxt = (widx_ff == IDX_W'(WINDOW_PEAKS - 1)) ? '0 : widx_ff + IDX_W'(1);
      fill_nxt = (fill_ff < CNT_W'(WINDOW_PEAKS)) ? fill_ff + CNT_W'(1) : fill_ff;
      old_sum  = SUM_W'(widx_nxt) + SUM_W'(WINDOW_PEAKS) - SUM_W'(fill_nxt);
      if (old_sum >= SUM_W'(WINDOW_PEAKS)) begin
         old_sum = old_sum - SUM_W'(WINDOW_PEAKS);
      end
      oldest_idx = old_sum[IDX_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      thr_high_in  = thr_high_ff;
      thr_low_in   = thr_low_ff;
      width_lim_in = width_lim_ff;
      min_ivl_in   = min_ivl_ff;
      max_ivl_in   = max_ivl_ff;
      width_cnt_in = width_cnt_ff;
      widx_in      = widx_ff;
      fill_in      = fill_ff;
      last_end_in  = last_end_ff;
      rate_in      = rate_ff;
      valid_in     = valid_ff;
      ts_in        = ts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bpm_in   = rsp_bpm_ff;
      rsp_user_in  = rsp_user_ff;
      ring_wr_en   = 1'b0;
      ring_rd_en   = 1'b0;
      div_req      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_THR_HIGH:  thr_high_in  = csr_wdata;
            CSR_THR_LOW:   thr_low_in   = csr_wdata;
            CSR_WIDTH_LIM: width_lim_in = csr_wdata;
            CSR_MIN_IVL:   min_ivl_in   = csr_wdata;
            CSR_MAX_IVL:   max_ivl_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ts_in    = ts;
               state_in = S_OUT;
               if (req_tuser) begin
                  rate_in      = '0;
                  valid_in     = 1'b0;
                  fill_in      = '0;
                  widx_in      = '0;
                  width_cnt_in = '0;
               end else if (width_cnt_ff != '0) begin
                  width_cnt_in = cnt_inc;
                  if (sample < $signed(thr_low_ff)) begin
                     width_cnt_in = '0;
                     last_end_in  = ts;
                     if (peak_ok) begin
                        ring_wr_en = 1'b1;
                        widx_in    = widx_nxt;
                        fill_in    = fill_nxt;
                        if (fill_nxt < CNT_W'(2)) begin
                           rate_in  = '0;
                           valid_in = 1'b0;
                        end else begin
                           ring_rd_en = 1'b1;
                           state_in   = S_READ;
                        end
                     end
                  end
               end else if (sample > $signed(thr_high_ff)) begin
                  width_cnt_in = 16'd1;
               end
            end
         end
         S_READ: begin
            div_req.start    = 1'b1;
            div_req.dividend = ts_ff - ring_rd_data;
            div_req.divisor  = DIV_W'(fill_ff) - DIV_W'(1);
            state_in         = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) begin
               if (div_quo == '0) begin
                  state_in = S_OUT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = MS_PER_MIN;
                  div_req.divisor  = div_quo;
                  state_in         = S_DIV2;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               if (div_quo >= BPM_MIN && div_quo <= BPM_MAX) begin
                  rate_in  = div_quo[BPM_W-1:0];
                  valid_in = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bpm_in   = valid_ff ? rate_ff : '0;
               rsp_user_in  = valid_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_high_ff  <= THR_HIGH_RST;
         thr_low_ff   <= THR_LOW_RST;
         width_lim_ff <= WIDTH_LIM_RST;
         min_ivl_ff   <= MIN_IVL_RST;
         max_ivl_ff   <= MAX_IVL_RST;
         width_cnt_ff <= '0;
         widx_ff      <= '0;
         fill_ff      <= '0;
         last_end_ff  <= '0;
         rate_ff      <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_high_ff  <= thr_high_in;
         thr_low_ff   <= thr_low_in;
         width_lim_ff <= width_lim_in;
         min_ivl_ff   <= min_ivl_in;
         max_ivl_ff   <= max_ivl_in;
         width_cnt_ff <= width_cnt_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         last_end_ff  <= last_end_in;
         rate_ff      <= rate_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ts_ff       <= ts_in;
      rsp_bpm_ff  <= rsp_bpm_in;
      rsp_user_ff <= rsp_user_in;
   end

   ehr_ring #(
      .DEPTH (WINDOW_PEAKS),
      .AW    (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (widx_ff),
      .wr_data (ts),
      .rd_en   (ring_rd_en),
      .rd_addr (oldest_idx),
      .rd_data (ring_rd_data)
   );

   ehr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BPM_W){1'b0}}, rsp_bpm_ff};
   assign rsp_tuser  = rsp_user_ff;

endmodule

[src/ehr_checker.sv]
// ----------------------------------------------------------------------------
// ehr_checker
// Port-level checks on the heart-rate result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ehr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ehr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import ehr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid rate carries nonzero value");

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata >= RSP_DATA_W'(BPM_MIN) && rsp_tdata <= RSP_DATA_W'(BPM_MAX))
      else $error("valid rate out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind ecg_heart_rate_from_peaks ehr_checker u_ehr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
